// ===== rtl/core/sorted_priority_queue_unit_defines.svh =====
// Assertion macros of the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// Shared types, codes and constants of the sorted priority queue.
package spq_pkg;

    // Defaults of the top-level parameters.
    localparam int SPQ_DEPTH        = 16;
    localparam int SPQ_TASK_BITS    = 32;
    localparam int SPQ_CONTEXT_BITS = 64;

    // Fixed field widths of the stream words.
    localparam int TASK_FIELD_W    = 32;
    localparam int CONTEXT_FIELD_W = 64;
    localparam int KEY_W           = 32;
    localparam int ACTION_W        = 2;
    localparam int STATUS_W        = 2;

    // Input word layout.
    localparam int IN_TASK_LSB  = 0;
    localparam int IN_CTX_LSB   = IN_TASK_LSB + TASK_FIELD_W;
    localparam int IN_KEY_LSB   = IN_CTX_LSB + CONTEXT_FIELD_W;
    localparam int IN_TDATA_W   = IN_KEY_LSB + KEY_W;
    localparam int IN_TUSER_W   = ACTION_W;

    // Output word layout; count and empty flag sit above the key.
    localparam int OUT_TASK_LSB = 0;
    localparam int OUT_CTX_LSB  = OUT_TASK_LSB + TASK_FIELD_W;
    localparam int OUT_KEY_LSB  = OUT_CTX_LSB + CONTEXT_FIELD_W;
    localparam int OUT_CNT_LSB  = OUT_KEY_LSB + KEY_W;
    localparam int OUT_TUSER_W  = 1 + STATUS_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT    = 2'd0,
        ACT_POP       = 2'd1,
        ACT_NORMALIZE = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_LOOP,
        ST_INS_PLACE,
        ST_POP_TAKE,
        ST_NRM_OFF,
        ST_NRM_LOOP,
        ST_RESP
    } state_t;

    // Logical slot that a read addresses.
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_IDX_M2,
        RD_IDX_P1
    } rd_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_ZERO,
        IDX_DEC,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_MOVE,
        WR_NEW,
        WR_NORM
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        idx_op_t idx_op;
        wr_op_t  wr_op;
        cnt_op_t cnt_op;
        logic    head_inc;
        logic    off_load;
        logic    status_load;
        status_t status;
        logic    out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t action;
        logic    count_zero;
        logic    count_full;
        logic    key_gt;
        logic    tail_neg;
        logic    idx_is_one;
        logic    idx_is_last;
        logic    out_busy;
    } sts_t;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  spq_pkg::sts_t sts,
    output spq_pkg::cmd_t cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.status_load = 1'b1;
                cmd.status      = STAT_OK;
                case (sts.action)
                    ACT_INSERT:
                    begin
                        if (sts.count_full)
                        begin
                            cmd.status = STAT_FULL;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                            if (sts.count_zero)
                            begin
                                state_next = ST_INS_PLACE;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_TAIL;
                                state_next = ST_INS_LOOP;
                            end
                        end
                    end
                    ACT_POP:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.status = STAT_EMPTY;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_HEAD;
                            state_next = ST_POP_TAKE;
                        end
                    end
                    ACT_NORMALIZE:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.status = STAT_EMPTY;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_TAIL;
                            state_next = ST_NRM_OFF;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            // Walk from the tail toward the head, moving each entry whose key
            // is not greater one slot back.
            ST_INS_LOOP:
            begin
                if (sts.key_gt)
                begin
                    cmd.wr_op  = WR_NEW;
                    cmd.cnt_op = CNT_INC;
                    state_next = ST_RESP;
                end
                else
                begin
                    cmd.wr_op  = WR_MOVE;
                    cmd.idx_op = IDX_DEC;
                    if (sts.idx_is_one)
                    begin
                        state_next = ST_INS_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_IDX_M2;
                    end
                end
            end
            ST_INS_PLACE:
            begin
                cmd.wr_op  = WR_NEW;
                cmd.cnt_op = CNT_INC;
                state_next = ST_RESP;
            end
            ST_POP_TAKE:
            begin
                cmd.head_inc = 1'b1;
                cmd.cnt_op   = CNT_DEC;
                state_next   = ST_RESP;
            end
            // Tail key is in the read register; only a negative one shifts keys.
            ST_NRM_OFF:
            begin
                if (sts.tail_neg)
                begin
                    cmd.off_load = 1'b1;
                    cmd.idx_op   = IDX_ZERO;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_HEAD;
                    state_next   = ST_NRM_LOOP;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            // One key rewritten per cycle while the next one is read.
            ST_NRM_LOOP:
            begin
                cmd.wr_op = WR_NORM;
                if (sts.idx_is_last)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                end
            end
            ST_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/spq_dpath.sv =====
// Datapath of the sorted priority queue: entry memories, pointers and output register.
module spq_dpath #(
    parameter int DEPTH        = spq_pkg::SPQ_DEPTH,
    parameter int TASK_BITS    = spq_pkg::SPQ_TASK_BITS,
    parameter int CONTEXT_BITS = spq_pkg::SPQ_CONTEXT_BITS,
    parameter int CNT_W        = $clog2(DEPTH + 1),
    parameter int OUT_TDATA_W  = ((spq_pkg::OUT_CNT_LSB + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::cmd_t                   cmd,
    output spq_pkg::sts_t                   sts,
    input  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [spq_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_TDATA_W-1:0]          m_tdata,
    output logic [spq_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import spq_pkg::*;

    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TASK_KEEP = (TASK_BITS < TASK_FIELD_W) ? TASK_BITS : TASK_FIELD_W;
    localparam int CTX_KEEP  = (CONTEXT_BITS < CONTEXT_FIELD_W) ? CONTEXT_BITS
                                                                : CONTEXT_FIELD_W;

    // Entry storage, addressed as a ring starting at the head slot.
    logic signed [KEY_W-1:0] key_mem  [DEPTH];
    logic [TASK_KEEP-1:0]    task_mem [DEPTH];
    logic [CTX_KEEP-1:0]     ctx_mem  [DEPTH];

    action_t                 act_reg;
    logic [TASK_KEEP-1:0]    new_task_reg;
    logic [CTX_KEEP-1:0]     new_ctx_reg;
    logic signed [KEY_W-1:0] new_key_reg;
    logic signed [KEY_W-1:0] rd_key_reg;
    logic [TASK_KEEP-1:0]    rd_task_reg;
    logic [CTX_KEEP-1:0]     rd_ctx_reg;
    logic signed [33:0]      off_reg;
    logic signed [33:0]      off_next;
    status_t                 status_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_next;
    logic [OUT_TUSER_W-1:0]  m_tuser_reg;
    logic [OUT_TUSER_W-1:0]  m_tuser_next;

    logic [ADDR_W-1:0]       head_reg;
    logic [ADDR_W-1:0]       head_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [ADDR_W-1:0]       idx_reg;
    logic [ADDR_W-1:0]       idx_next;
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;

    logic [CNT_W-1:0]        cnt_m1;
    logic [ADDR_W-1:0]       rd_log;
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    wr_key_en;
    logic                    wr_pay_en;
    logic signed [KEY_W-1:0] wr_key;
    logic [TASK_KEEP-1:0]    wr_task;
    logic [CTX_KEEP-1:0]     wr_ctx;
    logic signed [33:0]      norm_sum;
    logic signed [KEY_W-1:0] norm_key;
    logic signed [33:0]      tail_ext;
    logic signed [33:0]      half_sum;
    logic                    pop_ok;

    // Ring position of a logical slot.
    function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [ADDR_W-1:0] ofs);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= (ADDR_W + 1)'(DEPTH))
        begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign cnt_m1 = count_reg - CNT_W'(1);

    // Read address selection.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD:   rd_log = '0;
            RD_TAIL:   rd_log = cnt_m1[ADDR_W-1:0];
            RD_IDX_M2: rd_log = idx_reg - ADDR_W'(2);
            RD_IDX_P1: rd_log = idx_reg + ADDR_W'(1);
            default:   rd_log = '0;
        endcase
        rd_addr = ring_addr(head_reg, rd_log);
        wr_addr = ring_addr(head_reg, idx_reg);
    end

    // Key shifted by the normalize offset, saturated to the key range.
    always_comb
    begin
        norm_sum = {{2{rd_key_reg[KEY_W-1]}}, rd_key_reg} + off_reg;
        if (norm_sum > 34'sd2147483647)
        begin
            norm_key = 32'sh7FFFFFFF;
        end
        else if (norm_sum < -34'sd2147483648)
        begin
            norm_key = 32'sh80000000;
        end
        else
        begin
            norm_key = norm_sum[KEY_W-1:0];
        end
    end

    // Offset -(k + k/2) from the negative tail key, halving toward zero.
    always_comb
    begin
        tail_ext = {{2{rd_key_reg[KEY_W-1]}}, rd_key_reg};
        half_sum = tail_ext + {33'd0, rd_key_reg[KEY_W-1]};
        off_next = -(tail_ext + (half_sum >>> 1));
    end

    // Write port data.
    always_comb
    begin
        wr_key_en = (cmd.wr_op != WR_NONE);
        wr_pay_en = (cmd.wr_op == WR_MOVE) || (cmd.wr_op == WR_NEW);
        wr_task   = new_task_reg;
        wr_ctx    = new_ctx_reg;
        case (cmd.wr_op)
            WR_MOVE:
            begin
                wr_key  = rd_key_reg;
                wr_task = rd_task_reg;
                wr_ctx  = rd_ctx_reg;
            end
            WR_NEW:  wr_key = new_key_reg;
            WR_NORM: wr_key = norm_key;
            default: wr_key = new_key_reg;
        endcase
    end

    // Entry memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_key_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_pay_en)
        begin
            task_mem[wr_addr] <= wr_task;
            ctx_mem[wr_addr]  <= wr_ctx;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_task_reg <= task_mem[rd_addr];
            rd_ctx_reg  <= ctx_mem[rd_addr];
        end
    end

    // Pointer, count and index updates.
    always_comb
    begin
        head_next = head_reg;
        if (cmd.head_inc)
        begin
            head_next = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);
        end
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
        case (cmd.idx_op)
            IDX_COUNT: idx_next = count_reg[ADDR_W-1:0];
            IDX_ZERO:  idx_next = '0;
            IDX_DEC:   idx_next = idx_reg - ADDR_W'(1);
            IDX_INC:   idx_next = idx_reg + ADDR_W'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    // Result word assembled from the operation's outcome.
    always_comb
    begin
        pop_ok       = (act_reg == ACT_POP) && (status_reg == STAT_OK);
        m_tdata_next = '0;
        if (pop_ok)
        begin
            m_tdata_next[OUT_TASK_LSB +: TASK_KEEP] = rd_task_reg;
            m_tdata_next[OUT_CTX_LSB +: CTX_KEEP]   = rd_ctx_reg;
            m_tdata_next[OUT_KEY_LSB +: KEY_W]      = rd_key_reg;
        end
        m_tdata_next[OUT_CNT_LSB +: CNT_W] = count_reg;
        m_tdata_next[OUT_CNT_LSB + CNT_W]  = (count_reg == '0);
        m_tuser_next  = {status_reg, pop_ok};
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg      <= action_t'(s_tuser);
            new_task_reg <= s_tdata[IN_TASK_LSB +: TASK_KEEP];
            new_ctx_reg  <= s_tdata[IN_CTX_LSB +: CTX_KEEP];
            new_key_reg  <= s_tdata[IN_KEY_LSB +: KEY_W];
        end
        if (cmd.off_load)
        begin
            off_reg <= off_next;
        end
        if (cmd.status_load)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts.action      = act_reg;
        sts.count_zero  = (count_reg == '0);
        sts.count_full  = (count_reg == CNT_W'(DEPTH));
        sts.key_gt      = (rd_key_reg > new_key_reg);
        sts.tail_neg    = rd_key_reg[KEY_W-1];
        sts.idx_is_one  = (idx_reg == ADDR_W'(1));
        sts.idx_is_last = (CNT_W'(idx_reg) == cnt_m1);
        sts.out_busy    = m_tvalid_reg && !m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: controller, datapath and checks.
//
//   Channel   Direction  Contents
//   s_*       in         one operation word: action in tuser, entry fields in tdata
//   m_*       out        one result word per operation: flags in tuser, entry in tdata
//
// Normalize rewrites every held entry when the smallest key is negative; insert
// shifts back each entry whose key is not greater; a refused operation or the unused
// code goes straight to the response. One memory write port: one shift a cycle.
// Reset clears the head pointer and the count; entry memories are not cleared.
// A finished result waits in its state while the output register is still
// full; a new word is taken only once the previous result has been loaded.
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit #(
    parameter int DEPTH        = spq_pkg::SPQ_DEPTH,
    parameter int TASK_BITS    = spq_pkg::SPQ_TASK_BITS,
    parameter int CONTEXT_BITS = spq_pkg::SPQ_CONTEXT_BITS,
    parameter int CNT_W        = $clog2(DEPTH + 1),
    parameter int OUT_TDATA_W  = ((spq_pkg::OUT_CNT_LSB + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // task_in[31:0], context_in[95:32], key_in[127:96]
    input  logic [spq_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [spq_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // task_out, context_out, key_out, entry_count, is_empty, zero fill
    output logic [OUT_TDATA_W-1:0]          m_tdata,
    // data_valid[0], status[2:1]
    output logic [spq_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import spq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Terms watched by the checks at the end.
    logic [CNT_W-1:0] out_count;
    logic             out_empty;
    logic             count_ok;
    logic             pop_status_ok;
    logic             mem_write;
    logic             in_accept;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spq_dpath #(
        .DEPTH        (DEPTH),
        .TASK_BITS    (TASK_BITS),
        .CONTEXT_BITS (CONTEXT_BITS),
        .CNT_W        (CNT_W),
        .OUT_TDATA_W  (OUT_TDATA_W)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Result fields and handshake terms used by the assertions.
    assign out_count     = m_tdata[OUT_CNT_LSB +: CNT_W];
    assign out_empty     = m_tdata[OUT_CNT_LSB + CNT_W];
    assign count_ok      = (out_count <= CNT_W'(DEPTH)) && (out_empty == (out_count == '0));
    assign pop_status_ok = !m_tuser[0] || (m_tuser[2:1] == STAT_OK);
    assign mem_write     = (cmd.wr_op != WR_NONE);
    assign in_accept     = s_tvalid && s_tready;

    // Reported count stays within the depth and agrees with the empty flag.
    `SPQ_ASSERT_IMPL(a_count_range, clk, rst_n, m_tvalid, count_ok, "bad entry count or empty flag")

    // A returned entry always comes with an ok status.
    `SPQ_ASSERT_IMPL(a_pop_status, clk, rst_n, m_tvalid, pop_status_ok, "popped entry, bad status")

    // Entry memories are never written while the block waits for a word.
    `SPQ_ASSERT_IMPL(a_idle_no_write, clk, rst_n, mem_write, !s_tready, "memory write while idle")

    // Taking a word always moves the controller out of idle.
    `SPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_accept, !s_tready, "input taken twice in a row")

endmodule
